### rtl/nbr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbr_pkg
// shared types and constants of the nearest bin resampler
// ---------------------------------------------------------------------------
package nbr_pkg;

  localparam int unsigned REFERENCE_DEPTH_DEF = 1024;
  localparam int unsigned COUNT_W             = 11;
  localparam int unsigned SLOT_W              = 10;
  localparam int unsigned FREQ_W              = 32;
  localparam int unsigned POWER_W             = 32;
  localparam int unsigned MATCH_IDX_W         = 10;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = 11'd2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PICK
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic stop;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic advance;
    logic out_busy;
  } dp_status_t;

endpackage

### rtl/nbr_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbr_if
// request and result channels of the nearest bin resampler
// ---------------------------------------------------------------------------
interface nbr_in_if;
  logic                             valid;
  logic                             ready;
  nbr_pkg::cmd_e                    command;
  logic [nbr_pkg::SLOT_W-1:0]       entry_index;
  logic [nbr_pkg::FREQ_W-1:0]       frequency;
  logic [nbr_pkg::POWER_W-1:0]      power;
  logic                             first_of_pass;

  modport source (output valid, command, entry_index, frequency, power, first_of_pass,
                  input ready);
  modport sink   (input valid, command, entry_index, frequency, power, first_of_pass,
                  output ready);
endinterface

interface nbr_out_if;
  logic                             valid;
  logic                             ready;
  logic [nbr_pkg::POWER_W-1:0]      matched_power;
  logic [nbr_pkg::FREQ_W-1:0]       matched_frequency;
  logic [nbr_pkg::MATCH_IDX_W-1:0]  matched_index;

  modport source (output valid, matched_power, matched_frequency, matched_index,
                  input ready);
  modport sink   (input valid, matched_power, matched_frequency, matched_index,
                  output ready);
endinterface

### rtl/nearest_bin_resample_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_bin_resample_top
// nearest neighbour resampler over an ascending reference table
// ---------------------------------------------------------------------------
// requests arrive on req_i (valid/ready). a load request writes frequency and
// power into slot entry_index without leaving idle. a query request
// walks forward from the kept walk index (or from slot 1 when first_of_pass
// is set) while the target lies above the stored frequency, stopping at the
// last valid slot, then picks the lower neighbour if it is strictly nearer.
// the matched entry leaves on rsp_o (valid/ready) from an output register.
// a query passes start, walk, stop and pick; one table read per cycle
// through the single read port sets the walk speed. no new request is
// taken until a query has finished its pick, but one may be taken while
// the last result still waits on rsp_o. cfg_we_i/cfg_wdata_i set the entry
// count; the user must set it while no query is in flight, the block does
// not enforce this. reset clears the walk index to 1, the count to 2 and
// drops any result; the table contents are undefined until loaded. when the
// receiver stalls the result holds and the next query waits in its pick.
// ---------------------------------------------------------------------------
module nearest_bin_resample_top #(
  parameter int unsigned REFERENCE_DEPTH = nbr_pkg::REFERENCE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nbr_pkg::COUNT_W-1:0]   cfg_wdata_i,
  nbr_in_if.sink                        req_i,
  nbr_out_if.source                     rsp_o
);

  nbr_pkg::dp_cmd_t    dp_cmd;
  nbr_pkg::dp_status_t dp_status;

  nbr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (req_i.ready),
    .cmd_o        (dp_cmd),
    .status_i     (dp_status)
  );

  nbr_datapath #(
    .REFERENCE_DEPTH (REFERENCE_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .entry_index_i       (req_i.entry_index),
    .frequency_i         (req_i.frequency),
    .power_i             (req_i.power),
    .first_of_pass_i     (req_i.first_of_pass),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .out_valid_o         (rsp_o.valid),
    .out_ready_i         (rsp_o.ready),
    .matched_power_o     (rsp_o.matched_power),
    .matched_frequency_o (rsp_o.matched_frequency),
    .matched_index_o     (rsp_o.matched_index)
  );

endmodule

### rtl/nbr_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbr_ctrl
// sequencer for loads, the forward walk and the neighbour pick
// ---------------------------------------------------------------------------
module nbr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  nbr_pkg::cmd_e       in_command_i,
  output logic                in_ready_o,
  output nbr_pkg::dp_cmd_t    cmd_o,
  input  nbr_pkg::dp_status_t status_i
);

  nbr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nbr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      nbr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == nbr_pkg::CMD_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = nbr_pkg::ST_WALK;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      nbr_pkg::ST_WALK: begin
        if (status_i.advance) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.stop = 1'b1;
          state_d    = nbr_pkg::ST_PICK;
        end
      end
      nbr_pkg::ST_PICK: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = nbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nbr_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.start, cmd_o.step, cmd_o.stop, cmd_o.finish}))
    else $error("more than one datapath command");
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == nbr_pkg::ST_IDLE)
    else $error("load left idle");
`endif

endmodule

### rtl/nbr_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbr_datapath
// reference table, walk index, neighbour compare and result register
// ---------------------------------------------------------------------------
module nbr_datapath #(
  parameter int unsigned REFERENCE_DEPTH = nbr_pkg::REFERENCE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nbr_pkg::COUNT_W-1:0]       cfg_wdata_i,
  input  logic [nbr_pkg::SLOT_W-1:0]        entry_index_i,
  input  logic [nbr_pkg::FREQ_W-1:0]        frequency_i,
  input  logic [nbr_pkg::POWER_W-1:0]       power_i,
  input  logic                              first_of_pass_i,
  input  nbr_pkg::dp_cmd_t                  cmd_i,
  output nbr_pkg::dp_status_t               status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nbr_pkg::POWER_W-1:0]       matched_power_o,
  output logic [nbr_pkg::FREQ_W-1:0]        matched_frequency_o,
  output logic [nbr_pkg::MATCH_IDX_W-1:0]   matched_index_o
);

  localparam int unsigned AW      = $clog2(REFERENCE_DEPTH);
  localparam int unsigned CNT_W   = (AW + 1 > nbr_pkg::COUNT_W) ? AW + 1 : nbr_pkg::COUNT_W;
  localparam int unsigned ENTRY_W = nbr_pkg::POWER_W + nbr_pkg::FREQ_W;

  logic [ENTRY_W-1:0]             ref_mem_q [REFERENCE_DEPTH];
  logic [ENTRY_W-1:0]             rdata_q;
  logic [nbr_pkg::COUNT_W-1:0]    count_q;
  logic [AW-1:0]                  walk_q, walk_d;
  logic [AW-1:0]                  idx_q, idx_d;
  logic [nbr_pkg::FREQ_W-1:0]     target_q;
  logic [nbr_pkg::FREQ_W-1:0]     here_freq_q;
  logic [nbr_pkg::POWER_W-1:0]    here_power_q;
  logic                           out_valid_q;
  logic [nbr_pkg::POWER_W-1:0]    out_power_q;
  logic [nbr_pkg::FREQ_W-1:0]     out_freq_q;
  logic [nbr_pkg::MATCH_IDX_W-1:0] out_idx_q;

  logic [CNT_W-1:0]               count_ext;
  logic [CNT_W-1:0]               count_eff;
  logic [AW-1:0]                  last_idx;
  logic [AW-1:0]                  start_idx;
  logic [AW-1:0]                  start_raw;
  logic [AW-1:0]                  rd_addr;
  logic                           rd_en;
  logic                           slot_ok;
  logic [nbr_pkg::FREQ_W-1:0]     rd_freq;
  logic [nbr_pkg::POWER_W-1:0]    rd_power;
  logic [nbr_pkg::FREQ_W-1:0]     diff_here;
  logic [nbr_pkg::FREQ_W-1:0]     diff_low;
  logic                           take_low;

  assign rd_freq  = rdata_q[nbr_pkg::FREQ_W-1:0];
  assign rd_power = rdata_q[ENTRY_W-1:nbr_pkg::FREQ_W];

  // saturate the entry count into the table
  always_comb begin
    count_ext = CNT_W'(count_q);
    if (count_ext < CNT_W'(2)) begin
      count_eff = CNT_W'(2);
    end else if (count_ext > CNT_W'(REFERENCE_DEPTH)) begin
      count_eff = CNT_W'(REFERENCE_DEPTH);
    end else begin
      count_eff = count_ext;
    end
    last_idx = AW'(count_eff - CNT_W'(1));
  end

  always_comb begin
    start_raw = first_of_pass_i ? AW'(1) : walk_q;
    start_idx = (start_raw > last_idx) ? last_idx : start_raw;
  end

  assign status_o.advance  = (target_q > rd_freq) && (idx_q != last_idx);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    rd_en   = cmd_i.start || cmd_i.step || cmd_i.stop;
    rd_addr = start_idx;
    idx_d   = idx_q;
    if (cmd_i.start) begin
      idx_d   = start_idx;
      rd_addr = start_idx;
    end else if (cmd_i.step) begin
      idx_d   = idx_q + AW'(1);
      rd_addr = idx_q + AW'(1);
    end else if (cmd_i.stop) begin
      rd_addr = (idx_q == '0) ? idx_q : idx_q - AW'(1);
    end
  end

  assign slot_ok = 32'(entry_index_i) < 32'(REFERENCE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      ref_mem_q[AW'(entry_index_i)] <= {power_i, frequency_i};
    end
    if (rd_en) begin
      rdata_q <= ref_mem_q[rd_addr];
    end
  end

  // lower neighbour wins only when strictly nearer
  always_comb begin
    diff_here = (here_freq_q >= target_q) ? here_freq_q - target_q : target_q - here_freq_q;
    diff_low  = (rd_freq >= target_q) ? rd_freq - target_q : target_q - rd_freq;
    take_low  = (idx_q != '0) && (diff_here > diff_low);
    walk_d    = take_low ? idx_q - AW'(1) : idx_q;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.start) begin
      target_q <= frequency_i;
    end
    if (cmd_i.stop) begin
      here_freq_q  <= rd_freq;
      here_power_q <= rd_power;
    end
    if (cmd_i.finish) begin
      out_power_q <= take_low ? rd_power : here_power_q;
      out_freq_q  <= take_low ? rd_freq : here_freq_q;
      out_idx_q   <= nbr_pkg::MATCH_IDX_W'(walk_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= nbr_pkg::COUNT_RESET;
      walk_q      <= AW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        walk_q      <= walk_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign matched_power_o     = out_power_q;
  assign matched_frequency_o = out_freq_q;
  assign matched_index_o     = out_idx_q;

`ifndef SYNTH
  a_step_below_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> idx_q < last_idx)
    else $error("walk stepped past last entry");
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwrote a pending result");
  a_walk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> walk_q <= $past(last_idx))
    else $error("walk index beyond last entry");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the nearest bin resampler
// ---------------------------------------------------------------------------
// a short table of hand-checked load and query requests runs at the reset
// entry count. entry counts are then swept from the saturated extremes down
// to small random ones. each count loads an axis and queries it in ascending
// passes with random jumps, noise queries and stray reloads. oversized counts
// load only the head of the table, topped by the highest frequency so that
// no walk runs past it. an internal model tracks table, walk position and
// count and predicts every match. both channels idle at random and the
// result side once holds off long enough to back the block up.
// ---------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [nbr_pkg::POWER_W-1:0]     power;
    logic [nbr_pkg::FREQ_W-1:0]      freq;
    logic [nbr_pkg::MATCH_IDX_W-1:0] idx;
  } match_t;

  typedef struct {
    nbr_pkg::cmd_e               command;
    logic [nbr_pkg::SLOT_W-1:0]  slot;
    logic [nbr_pkg::FREQ_W-1:0]  freq;
    logic [nbr_pkg::POWER_W-1:0] power;
    logic                        fresh;
    bit                          typed;
    match_t                      want;
  } resample_req_t;

  localparam int DIRECTED_ROWS   = 19;
  localparam int TABLE_DEPTH     = nbr_pkg::REFERENCE_DEPTH_DEF;
  localparam int BIG_TABLE_LOADS = 64;
  localparam int ITEM_TARGET     = 400;

  logic                          clk_i  = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic [nbr_pkg::COUNT_W-1:0]   cfg_wdata_i;

  nbr_in_if  request_ch ();
  nbr_out_if result_ch ();

  nearest_bin_resample_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (request_ch),
    .rsp_o       (result_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic [nbr_pkg::FREQ_W-1:0]  tbl_freq  [TABLE_DEPTH];
  logic [nbr_pkg::POWER_W-1:0] tbl_power [TABLE_DEPTH];
  int unsigned                 walk_pos    = 1;
  logic [nbr_pkg::COUNT_W-1:0] entry_count = nbr_pkg::COUNT_RESET;

  // stimulus side copy of the loaded axis, only used to shape targets
  logic [nbr_pkg::FREQ_W-1:0]  axis [TABLE_DEPTH];

  resample_req_t request_fifo [$];
  match_t        match_expected [$];
  bit            sender_busy    = 1'b0;
  bit            hold_results   = 1'b0;
  int unsigned   failures       = 0;
  int unsigned   loads_taken    = 0;
  int unsigned   queries_taken  = 0;
  int unsigned   results_seen   = 0;
  int unsigned   items_queued   = 0;

  resample_req_t directed [DIRECTED_ROWS] = '{
    // command           slot     frequency      power          first typed want
    '{nbr_pkg::CMD_LOAD,  10'd0,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{nbr_pkg::CMD_LOAD,  10'd1,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0000, 10'd0}},
    '{nbr_pkg::CMD_QUERY, 10'h3FF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0000, 10'd0}},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 32'hFFFF_FFFF, 10'd1}},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 32'hFFFF_FFFF, 10'd1}},
    // descending target, then the index zero case
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0000, 10'd0}},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0000, 10'd0}},
    '{nbr_pkg::CMD_LOAD,  10'd0,   32'd100,       32'hA5A5_A5A5, 1'b0, 1'b0, '0},
    '{nbr_pkg::CMD_LOAD,  10'd1,   32'd200,       32'h5A5A_5A5A, 1'b0, 1'b0, '0},
    // equal distance keeps the upper entry
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'd150,       32'h0000_0000, 1'b1, 1'b1,
      '{32'h5A5A_5A5A, 32'd200, 10'd1}},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'd149,       32'h0000_0000, 1'b0, 1'b1,
      '{32'hA5A5_A5A5, 32'd100, 10'd0}},
    // above the last entry
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'd250,       32'h0000_0000, 1'b0, 1'b1,
      '{32'h5A5A_5A5A, 32'd200, 10'd1}},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'd50,        32'h0000_0000, 1'b1, 1'b1,
      '{32'hA5A5_A5A5, 32'd100, 10'd0}},
    // duplicate frequencies
    '{nbr_pkg::CMD_LOAD,  10'd1,   32'd100,       32'h1234_5678, 1'b0, 1'b0, '0},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'd100,       32'h0000_0000, 1'b1, 1'b1,
      '{32'h1234_5678, 32'd100, 10'd1}},
    '{nbr_pkg::CMD_QUERY, 10'd0,   32'd99,        32'h0000_0000, 1'b0, 1'b0, '0},
    '{nbr_pkg::CMD_LOAD,  10'h3FF, 32'h8000_0001, 32'h7FFF_FFFE, 1'b0, 1'b0, '0},
    '{nbr_pkg::CMD_QUERY, 10'h3FF, 32'd1,         32'hFFFF_FFFF, 1'b1, 1'b0, '0}
  };

  function automatic int unsigned live_entries(input logic [nbr_pkg::COUNT_W-1:0] value);
    if (value < 2) return 2;
    if (value > TABLE_DEPTH) return TABLE_DEPTH;
    return 32'(value);
  endfunction

  function automatic logic [nbr_pkg::FREQ_W-1:0] distance(
    input logic [nbr_pkg::FREQ_W-1:0] a,
    input logic [nbr_pkg::FREQ_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic bit nearest_match(input resample_req_t r, output match_t m);
    int unsigned last;
    int unsigned idx;
    m = '0;
    if (r.command == nbr_pkg::CMD_LOAD) begin
      tbl_freq[r.slot]  = r.freq;
      tbl_power[r.slot] = r.power;
      return 1'b0;
    end
    last = live_entries(entry_count) - 1;
    idx  = r.fresh ? 1 : walk_pos;
    if (idx > last) idx = last;
    while (r.freq > tbl_freq[idx]) begin
      if (idx >= last) begin
        idx = last;
        break;
      end
      idx++;
    end
    if (idx > 0) begin
      if (distance(tbl_freq[idx], r.freq) > distance(tbl_freq[idx-1], r.freq)) idx--;
    end
    walk_pos = idx;
    m.power  = tbl_power[idx];
    m.freq   = tbl_freq[idx];
    m.idx    = idx[nbr_pkg::MATCH_IDX_W-1:0];
    return 1'b1;
  endfunction

  task automatic queue_load(input int unsigned slot,
                            input logic [nbr_pkg::FREQ_W-1:0] freq,
                            input logic [nbr_pkg::POWER_W-1:0] power);
    resample_req_t r;
    r.command = nbr_pkg::CMD_LOAD;
    r.slot    = slot[nbr_pkg::SLOT_W-1:0];
    r.freq    = freq;
    r.power   = power;
    r.fresh   = 1'($urandom_range(0, 1));
    r.typed   = 1'b0;
    r.want    = '0;
    if (slot < TABLE_DEPTH) axis[slot] = freq;
    items_queued++;
    request_fifo.insert(request_fifo.size(), r);
  endtask

  task automatic queue_query(input logic [nbr_pkg::FREQ_W-1:0] target, input logic fresh);
    resample_req_t r;
    logic [31:0]   noise;
    noise     = $urandom;
    r.command = nbr_pkg::CMD_QUERY;
    r.slot    = noise[nbr_pkg::SLOT_W-1:0];
    r.freq    = target;
    r.power   = $urandom;
    r.fresh   = fresh;
    r.typed   = 1'b0;
    r.want    = '0;
    items_queued++;
    request_fifo.insert(request_fifo.size(), r);
  endtask

  // wait for the block to go quiet
  task automatic settle();
    do @(posedge clk_i);
    while (request_fifo.size() != 0 || sender_busy || match_expected.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_count(input logic [nbr_pkg::COUNT_W-1:0] value);
    settle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    entry_count  = value;
  endtask

  task automatic run_phase(input int unsigned n, input bit squeeze, input bit capped);
    longint unsigned            level;
    longint unsigned            span;
    logic [nbr_pkg::FREQ_W-1:0] target;
    logic [nbr_pkg::FREQ_W-1:0] prev;
    logic [nbr_pkg::FREQ_W-1:0] entry_freq;
    int unsigned                pos;
    int unsigned                nq;
    int unsigned                s;
    int unsigned                reload_top;
    bit                         noisy_table;
    logic                       fresh;
    noisy_table = ($urandom_range(0, 7) == 0);
    level = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 1000));
    span  = (64'hFFFF_FFFF - level) / n;
    // the top slot of a partly loaded table must stay the highest frequency
    reload_top = capped ? n - 2 : n - 1;
    for (s = 0; s < n; s++) begin
      if (noisy_table) begin
        entry_freq = $urandom;
      end else begin
        entry_freq = level[nbr_pkg::FREQ_W-1:0];
        if ($urandom_range(0, 9) != 0) level += 64'($urandom_range(0, span[31:0]));
      end
      if (capped && s == n - 1) entry_freq = '1;
      queue_load(s, entry_freq, $urandom);
    end
    if (squeeze) hold_results = 1'b1;
    pos   = 0;
    prev  = '0;
    fresh = 1'($urandom_range(0, 1));
    nq    = $urandom_range(20, 50);
    repeat (nq) begin
      case ($urandom_range(0, 11))
        0: queue_load($urandom_range(0, reload_top), $urandom, $urandom);
        1: queue_query($urandom, 1'($urandom_range(0, 1)));
        default: begin
          if (pos >= n) begin
            target = axis[n-1] + $urandom_range(0, ~axis[n-1]);
          end else begin
            case ($urandom_range(0, 3))
              0: target = axis[pos];
              1: target = axis[pos] - 1 + $urandom_range(0, 2);
              2: target = (pos == 0) ? $urandom_range(0, axis[0])
                                     : axis[pos-1] + (axis[pos] - axis[pos-1]) / 2;
              default: target = (pos == 0) ? $urandom_range(0, axis[0])
                                           : $urandom_range(axis[pos-1], axis[pos]);
            endcase
          end
          if (target < prev) target = prev;
          queue_query(target, fresh);
          prev  = target;
          fresh = 1'b0;
          pos  += ($urandom_range(0, 9) == 0) ? $urandom_range(0, n / 4)
                                              : $urandom_range(0, 2);
          if (pos > n) pos = n;
          if ($urandom_range(0, 9) == 0) begin
            pos   = 0;
            prev  = '0;
            fresh = 1'b1;
          end
        end
      endcase
    end
  endtask

  initial begin : request_driver
    resample_req_t item;
    match_t        m;
    int unsigned   pause;
    bit            steady;
    steady = 1'b0;
    request_ch.valid         <= 1'b0;
    request_ch.command       <= nbr_pkg::CMD_LOAD;
    request_ch.entry_index   <= '0;
    request_ch.frequency     <= '0;
    request_ch.power         <= '0;
    request_ch.first_of_pass <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (request_fifo.size() == 0) begin
        request_ch.valid <= 1'b0;
        @(posedge clk_i);
      end else begin
        item        = request_fifo.pop_front();
        sender_busy = 1'b1;
        if ($urandom_range(0, 39) == 0) steady = !steady;
        pause = steady ? 0 : $urandom_range(0, 6);
        if (pause != 0) begin
          request_ch.valid <= 1'b0;
          repeat (pause) @(posedge clk_i);
        end
        request_ch.valid         <= 1'b1;
        request_ch.command       <= item.command;
        request_ch.entry_index   <= item.slot;
        request_ch.frequency     <= item.freq;
        request_ch.power         <= item.power;
        request_ch.first_of_pass <= item.fresh;
        @(posedge clk_i);
        while (request_ch.ready !== 1'b1) @(posedge clk_i);
        if (item.command == nbr_pkg::CMD_LOAD) loads_taken++;
        else queries_taken++;
        if (nearest_match(item, m)) begin
          match_expected.insert(match_expected.size(), item.typed ? item.want : m);
        end
        sender_busy = 1'b0;
      end
    end
  end

  initial begin : result_sink
    match_t      want;
    int unsigned pause;
    bit          steady;
    steady = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_results) begin
        result_ch.ready <= 1'b0;
        hold_results     = 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) steady = !steady;
      pause = steady ? 0 : $urandom_range(0, 6);
      if (pause != 0) begin
        result_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (result_ch.valid !== 1'b1) @(posedge clk_i);
      results_seen++;
      if (match_expected.size() == 0) begin
        $error("unexpected result: index %0d frequency %h power %h",
               result_ch.matched_index, result_ch.matched_frequency,
               result_ch.matched_power);
        failures++;
      end else begin
        want = match_expected.pop_front();
        if (result_ch.matched_power !== want.power) begin
          $error("matched_power: expected %h, got %h", want.power,
                 result_ch.matched_power);
          failures++;
        end
        if (result_ch.matched_frequency !== want.freq) begin
          $error("matched_frequency: expected %h, got %h", want.freq,
                 result_ch.matched_frequency);
          failures++;
        end
        if (result_ch.matched_index !== want.idx) begin
          $error("matched_index: expected %0d, got %0d", want.idx,
                 result_ch.matched_index);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [nbr_pkg::COUNT_W-1:0] first_counts [6];
    logic [nbr_pkg::COUNT_W-1:0] pick;
    int unsigned                 draw;
    int unsigned                 n_live;
    int unsigned                 n_load;
    int unsigned                 phase_no;
    first_counts = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd3, 11'd2};
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) request_fifo.insert(request_fifo.size(), directed[i]);
    items_queued = DIRECTED_ROWS;
    phase_no     = 0;
    while (items_queued < ITEM_TARGET) begin
      if (phase_no < 6) begin
        pick = first_counts[phase_no];
      end else begin
        if ($urandom_range(0, 7) == 0) draw = $urandom_range(41, BIG_TABLE_LOADS);
        else draw = $urandom_range(2, 40);
        pick = draw[nbr_pkg::COUNT_W-1:0];
      end
      set_count(pick);
      n_live = live_entries(pick);
      n_load = (n_live > BIG_TABLE_LOADS) ? BIG_TABLE_LOADS : n_live;
      run_phase(n_load, phase_no == 4, n_live > n_load);
      phase_no++;
    end
    settle();
    repeat (16) @(posedge clk_i);
    $display("%0d loads and %0d queries over %0d entry counts, 2 to %0d entries",
             loads_taken, queries_taken, phase_no + 1, TABLE_DEPTH);
    $display("%0d results checked, %0d field mismatches", results_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
